// ===== rtl/core/suv_pkg.sv =====
// ----------------------------------------------------------------------------
// suv_pkg
// Types and constants shared by the spherical texture-coordinate mapper:
// fixed-point widths, CORDIC arctangent table and the stage payloads.
// ----------------------------------------------------------------------------
package suv_pkg;

    // Coordinate and result field widths
    localparam int CoordBits   = 16;
    localparam int TexBits     = 16;

    // Guard bits applied to coordinates before rotation and square root
    localparam int SqShift     = (63 - 2 * CoordBits) / 2;

    // Square-root datapath
    localparam int SqBits      = 2 * CoordBits;
    localparam int RootBits    = CoordBits + SqShift;
    localparam int RemBits     = RootBits + 3;

    // CORDIC datapath: scaled coordinate plus growth margin
    localparam int CordBits    = CoordBits + SqShift + 3;
    localparam int AngBits     = 32;
    localparam int AtanEntries = 24;

    localparam logic [AngBits-1:0] HalfTurn         = 32'h8000_0000;
    localparam logic [AngBits-1:0] ThreeQuarterTurn = 32'hC000_0000;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [AngBits-1:0] AtanTurns [AtanEntries] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [CoordBits-1:0] pos_x;
        logic signed [CoordBits-1:0] pos_y;
        logic signed [CoordBits-1:0] pos_z;
    } suv_in_t;

    typedef struct packed {
        logic signed [TexBits-1:0] tex_u;
        logic        [TexBits-1:0] tex_v;
        logic                      degenerate;
    } suv_out_t;

    // Payload of one square-root cell
    typedef struct packed {
        logic [SqBits-1:0]   m;
        logic [RemBits-1:0]  rem;
        logic [RootBits-1:0] root;
        suv_in_t             pos;
    } suv_root_t;

    // One vector under rotation and its accumulated angle
    typedef struct packed {
        logic signed [CordBits-1:0] a;
        logic signed [CordBits-1:0] b;
        logic        [AngBits-1:0]  ang;
    } suv_vec_t;

    typedef struct packed {
        logic degenerate;
        logic z_zero;
        logic x_neg;
        logic z_neg;
    } suv_flags_t;

    // Payload of one CORDIC cell: azimuth and polar rotations side by side
    typedef struct packed {
        suv_vec_t   az;
        suv_vec_t   pol;
        suv_flags_t flags;
    } suv_cordic_t;

endpackage

// ===== rtl/core/spherical_uv_mapping.sv =====
// ----------------------------------------------------------------------------
// spherical_uv_mapping
// Throughput: one vertex per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the square-root cell chain (one root bit per cell) followed
// by the CORDIC cell chain (one iteration per cell).
// Reset clears every valid bit; no result appears until a transfer enters.
// ----------------------------------------------------------------------------
module spherical_uv_mapping #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  suv_pkg::suv_in_t  vertex,
    output logic              done,
    output suv_pkg::suv_out_t result
);
    import suv_pkg::*;

    localparam int Latency = RootBits + CORDIC_STAGES + 4;

    localparam logic signed [AngBits:0] PosHalf = {1'b0, HalfTurn};
    localparam logic signed [AngBits:0] NegHalf = -PosHalf;
    localparam logic signed [AngBits:0] URound  = 33'sd32768;
    localparam logic        [AngBits-1:0] VRound = 32'd16384;
    localparam logic signed [TexBits:0] UMax    = 17'sd32767;

    logic accept;

    // Squaring stage
    logic                        valid_a_reg;
    suv_in_t                     pos_a_reg;
    logic        [SqBits-1:0]    sqx_a_reg;
    logic        [SqBits-1:0]    sqz_a_reg;
    logic        [SqBits-1:0]    sqx_next;
    logic        [SqBits-1:0]    sqz_next;
    logic signed [CoordBits-1:0] in_x;
    logic signed [CoordBits-1:0] in_z;
    logic signed [SqBits-1:0]    prod_x;
    logic signed [SqBits-1:0]    prod_z;

    // Radicand stage
    logic      head_valid_reg;
    suv_root_t head_reg;
    suv_root_t head_next;

    // Square-root chain
    logic      root_valid [RootBits+1];
    suv_root_t root_bus   [RootBits+1];

    // Pre-rotation stage
    logic                       init_valid_reg;
    suv_cordic_t                init_reg;
    suv_cordic_t                init_next;
    logic signed [CoordBits-1:0] ix;
    logic signed [CoordBits-1:0] iy;
    logic signed [CoordBits-1:0] iz;
    logic signed [CordBits-1:0]  xs;
    logic signed [CordBits-1:0]  ys;
    logic signed [CordBits-1:0]  zs;
    logic signed [CordBits-1:0]  rs;

    // CORDIC chain
    logic        cord_valid [CORDIC_STAGES+1];
    suv_cordic_t cord_bus   [CORDIC_STAGES+1];

    // Output stage
    logic                       done_reg;
    suv_out_t                   result_reg;
    suv_out_t                   result_next;
    suv_cordic_t                fin;
    logic signed [AngBits:0]    au;
    logic signed [AngBits:0]    sum_u;
    logic signed [TexBits:0]    uq;
    logic        [AngBits-1:0]  av;
    logic        [AngBits-1:0]  sum_v;
    logic        [TexBits:0]    vq;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Square x and z
    // ------------------------------------------------------------------
    always_comb
    begin
        in_x     = vertex.pos_x;
        in_z     = vertex.pos_z;
        prod_x   = in_x * in_x;
        prod_z   = in_z * in_z;
        sqx_next = $unsigned(prod_x);
        sqz_next = $unsigned(prod_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg    <= 1'b0;
            head_valid_reg <= 1'b0;
            init_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            valid_a_reg    <= accept;
            head_valid_reg <= valid_a_reg;
            init_valid_reg <= root_valid[RootBits];
            done_reg       <= cord_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        pos_a_reg  <= vertex;
        sqx_a_reg  <= sqx_next;
        sqz_a_reg  <= sqz_next;
        head_reg   <= head_next;
        init_reg   <= init_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Radicand x*x + z*z; guard bits enter later as zero digit pairs
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next.m    = sqx_a_reg + sqz_a_reg;
        head_next.rem  = '0;
        head_next.root = '0;
        head_next.pos  = pos_a_reg;
    end

    assign root_valid[0] = head_valid_reg;
    assign root_bus[0]   = head_reg;

    for (genvar g = 0; g < RootBits; g++)
    begin : g_root
        suv_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (root_valid[g]),
            .in_data   (root_bus[g]),
            .out_valid (root_valid[g+1]),
            .out_data  (root_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale coordinates and fold the left half plane
    // ------------------------------------------------------------------
    always_comb
    begin
        ix = root_bus[RootBits].pos.pos_x;
        iy = root_bus[RootBits].pos.pos_y;
        iz = root_bus[RootBits].pos.pos_z;
        xs = {{(CordBits-CoordBits){ix[CoordBits-1]}}, ix} <<< SqShift;
        ys = {{(CordBits-CoordBits){iy[CoordBits-1]}}, iy} <<< SqShift;
        zs = {{(CordBits-CoordBits){iz[CoordBits-1]}}, iz} <<< SqShift;
        rs = {{(CordBits-RootBits){1'b0}}, root_bus[RootBits].root};

        if (ix[CoordBits-1])
        begin
            init_next.az.a   = -xs;
            init_next.az.b   = -zs;
            init_next.az.ang = HalfTurn;
        end
        else
        begin
            init_next.az.a   = xs;
            init_next.az.b   = zs;
            init_next.az.ang = '0;
        end

        if (iy[CoordBits-1])
        begin
            init_next.pol.a   = -ys;
            init_next.pol.b   = -rs;
            init_next.pol.ang = HalfTurn;
        end
        else
        begin
            init_next.pol.a   = ys;
            init_next.pol.b   = rs;
            init_next.pol.ang = '0;
        end

        init_next.flags.degenerate = (ix == '0) && (iy == '0) && (iz == '0);
        init_next.flags.z_zero     = (iz == '0);
        init_next.flags.x_neg      = ix[CoordBits-1];
        init_next.flags.z_neg      = iz[CoordBits-1];
    end

    assign cord_valid[0] = init_valid_reg;
    assign cord_bus[0]   = init_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        suv_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cord_valid[g]),
            .in_data   (cord_bus[g]),
            .out_valid (cord_valid[g+1]),
            .out_data  (cord_bus[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Resolve seams, round and saturate
    // ------------------------------------------------------------------
    always_comb
    begin
        fin = cord_bus[CORDIC_STAGES];

        // azimuth: on the x axis the angle is exact; else clamp to the side of z
        if (fin.flags.z_zero)
        begin
            au = fin.flags.x_neg ? PosHalf : '0;
        end
        else
        begin
            au = {fin.az.ang[AngBits-1], fin.az.ang};
            if (!fin.flags.z_neg && fin.az.ang[AngBits-1])
            begin
                au = PosHalf;
            end
            else if (fin.flags.z_neg && !fin.az.ang[AngBits-1] && fin.az.ang != '0)
            begin
                au = NegHalf;
            end
        end
        sum_u = au + URound;
        uq    = sum_u[AngBits -: TexBits+1];

        // polar angle: clamp residue into [0, half turn]
        if (fin.pol.ang > ThreeQuarterTurn)
        begin
            av = '0;
        end
        else if (fin.pol.ang > HalfTurn)
        begin
            av = HalfTurn;
        end
        else
        begin
            av = fin.pol.ang;
        end
        sum_v = av + VRound;
        vq    = sum_v[AngBits-1 -: TexBits+1];

        if (fin.flags.degenerate)
        begin
            result_next.tex_u      = '0;
            result_next.tex_v      = '0;
            result_next.degenerate = 1'b1;
        end
        else
        begin
            result_next.tex_u      = (uq > UMax) ? UMax[TexBits-1:0] : uq[TexBits-1:0];
            result_next.tex_v      = vq[TexBits] ? '1 : vq[TexBits-1:0];
            result_next.degenerate = 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_done : assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##Latency done
    ) else $error("transfer did not produce a result after the pipeline latency");

    a_done_from_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, Latency)
    ) else $error("result strobe without a matching input transfer");

    a_degenerate_flag : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (result.degenerate ==
                  $past((vertex.pos_x == '0) && (vertex.pos_y == '0) &&
                        (vertex.pos_z == '0), Latency))
    ) else $error("degenerate flag does not match the zero-vector input");

endmodule

// ===== rtl/core/suv_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// suv_sqrt_cell
// One digit of a restoring integer square root: takes the next two radicand
// bits, decides one root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module suv_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  suv_pkg::suv_root_t  in_data,
    output logic                out_valid,
    output suv_pkg::suv_root_t  out_data
);
    import suv_pkg::*;

    logic               valid_reg;
    suv_root_t          data_reg;
    suv_root_t          data_next;
    logic [RemBits-1:0] cur;
    logic [RemBits-1:0] trial;
    logic               fits;

    always_comb
    begin
        cur   = {in_data.rem[RemBits-3:0], in_data.m[SqBits-1 -: 2]};
        trial = RemBits'({in_data.root, 2'b01});
        fits  = (cur >= trial);

        data_next      = in_data;
        data_next.m    = in_data.m << 2;
        data_next.rem  = fits ? (cur - trial) : cur;
        data_next.root = {in_data.root[RootBits-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/suv_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// suv_cordic_cell
// One vectoring CORDIC iteration, applied to the azimuth and the polar
// vector in parallel; flags ride along to the output stage.
// ----------------------------------------------------------------------------
module suv_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  suv_pkg::suv_cordic_t  in_data,
    output logic                  out_valid,
    output suv_pkg::suv_cordic_t  out_data
);
    import suv_pkg::*;

    logic        valid_reg;
    suv_cordic_t data_reg;
    suv_cordic_t data_next;

    // Drive b toward zero; floor shifts match arithmetic right shifts
    function automatic suv_vec_t rotate(input suv_vec_t v);
        logic signed [CordBits-1:0] a;
        logic signed [CordBits-1:0] b;
        logic signed [CordBits-1:0] da;
        logic signed [CordBits-1:0] db;
        suv_vec_t                   r;
        a  = v.a;
        b  = v.b;
        da = b >>> STAGE;
        db = a >>> STAGE;
        r  = v;
        if (b[CordBits-1])
        begin
            r.a   = a - da;
            r.b   = b + db;
            r.ang = v.ang - AtanTurns[STAGE];
        end
        else if (b != '0)
        begin
            r.a   = a + da;
            r.b   = b - db;
            r.ang = v.ang + AtanTurns[STAGE];
        end
        return r;
    endfunction

    always_comb
    begin
        data_next       = in_data;
        data_next.az    = rotate(in_data.az);
        data_next.pol   = rotate(in_data.pol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
